### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("path timing check failed");

// Condition that must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("path timing check failed");

`endif

### rtl/core/ttsp_pkg.sv
// ---------------------------------------------------------------------------
// ttsp_pkg
// Types and constants shared by the turn-then-straight path timing pipeline.
// ---------------------------------------------------------------------------
package ttsp_pkg;

  // Datapath widths: CORDIC vector words, angle words, quotient and dividend.
  localparam int RW = 35;
  localparam int ZW = 34;
  localparam int QW = 27;
  localparam int DW = 64;
  localparam int TAB_LEN = 24;
  localparam int SQRT_STEPS = 32;

  // Arctangent of 2^-i, with 2^31 standing for pi.
  localparam logic [29:0] ANGLE_STEP [TAB_LEN] = '{
    30'd536870912, 30'd316933405, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10680862, 30'd5340245, 30'd2670163, 30'd1335086,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41721, 30'd20860,
    30'd10430, 30'd5215, 30'd2607, 30'd1303, 30'd651, 30'd325, 30'd162, 30'd81
  };

  localparam logic signed [ZW-1:0] HALF_PI = 34'sd1073741824;
  localparam logic signed [ZW-1:0] FULL_PI = 34'sd2147483648;

  // CORDIC gain correction in Q24, arc and line time factors, time ceiling.
  localparam logic [23:0] INV_GAIN = 24'd10188014;
  localparam logic [18:0] ARC_K    = 19'd392699;
  localparam logic [13:0] LINE_K   = 14'd15625;
  localparam logic [QW-1:0] TIME_MAX = 27'd134217727;

  // Register map, one 32-bit word per register.
  typedef enum logic [2:0] {
    REG_RIGHT_RADIUS = 3'd0,
    REG_LEFT_RADIUS  = 3'd1,
    REG_STRAIGHT_SPD = 3'd2,
    REG_CURVE_SPD    = 3'd3,
    REG_CENTER_DUTY  = 3'd4,
    REG_RIGHT_TRIM   = 3'd5,
    REG_LEFT_TRIM    = 3'd6
  } reg_idx_t;

  localparam logic [9:0]  RST_RIGHT_RADIUS = 10'd34;
  localparam logic [9:0]  RST_LEFT_RADIUS  = 10'd30;
  localparam logic [15:0] RST_STRAIGHT_SPD = 16'd3584;
  localparam logic [15:0] RST_CURVE_SPD    = 16'd3098;
  localparam logic [15:0] RST_CENTER_DUTY  = 16'd3506;
  localparam logic [15:0] RST_RIGHT_TRIM   = 16'd983;
  localparam logic [15:0] RST_LEFT_TRIM    = 16'd950;

  // Per-transaction sideband that travels beside the datapath.
  typedef struct packed {
    logic        valid;
    logic        inv;
    logic        right;
    logic        x_neg;
    logic [15:0] heading;
    logic [33:0] x_abs;
    logic [33:0] y_abs;
    logic [9:0]  rad;
    logic [31:0] line;
    logic [15:0] new_h;
    logic [15:0] duty;
    logic        sat1;
    logic        sat2;
    logic        nz1;
    logic        nz2;
  } side_t;

endpackage

### rtl/core/ttsp_cordic_cell.sv
// ---------------------------------------------------------------------------
// ttsp_cordic_cell
// One registered CORDIC micro-rotation, in rotation or vectoring mode.
// ---------------------------------------------------------------------------
module ttsp_cordic_cell #(
  parameter int STEP   = 0,
  parameter bit VECTOR = 1'b0
) (
  input  logic                             clk,
  input  logic signed [ttsp_pkg::RW-1:0]   x_in,
  input  logic signed [ttsp_pkg::RW-1:0]   y_in,
  input  logic signed [ttsp_pkg::ZW-1:0]   z_in,
  output logic signed [ttsp_pkg::RW-1:0]   x_out,
  output logic signed [ttsp_pkg::RW-1:0]   y_out,
  output logic signed [ttsp_pkg::ZW-1:0]   z_out
);

  logic signed [ttsp_pkg::RW-1:0] sx;
  logic signed [ttsp_pkg::RW-1:0] sy;
  logic signed [ttsp_pkg::ZW-1:0] ang;
  logic                           ccw;

  // Floor shifts of both coordinates and the angle of this step.
  assign sx  = x_in >>> STEP;
  assign sy  = y_in >>> STEP;
  assign ang = $signed({4'b0, ttsp_pkg::ANGLE_STEP[STEP]});

  // Rotation follows the residual angle; vectoring drives y toward zero.
  assign ccw = VECTOR ? !(y_in > 0) : (z_in >= 0);

  always_ff @(posedge clk) begin
    if (ccw) begin
      x_out <= x_in - sy;
      y_out <= y_in + sx;
      z_out <= z_in - ang;
    end else begin
      x_out <= x_in + sy;
      y_out <= y_in - sx;
      z_out <= z_in + ang;
    end
  end

endmodule

### rtl/core/ttsp_sqrt_cell.sv
// ---------------------------------------------------------------------------
// ttsp_sqrt_cell
// One registered step of the digit-by-digit integer square root.
// ---------------------------------------------------------------------------
module ttsp_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                      clk,
  input  logic [ttsp_pkg::DW-1:0]   rem_in,
  input  logic [ttsp_pkg::DW-1:0]   root_in,
  output logic [ttsp_pkg::DW-1:0]   rem_out,
  output logic [ttsp_pkg::DW-1:0]   root_out
);

  localparam logic [ttsp_pkg::DW-1:0] BIT_VAL = 64'd1 << (62 - 2 * STEP);

  logic [ttsp_pkg::DW:0] trial;
  logic                  fits;

  // Try to take the current result bit out of the remainder.
  assign trial = {1'b0, root_in} + {1'b0, BIT_VAL};
  assign fits  = {1'b0, rem_in} >= trial;

  always_ff @(posedge clk) begin
    if (fits) begin
      rem_out  <= rem_in - trial[ttsp_pkg::DW-1:0];
      root_out <= (root_in >> 1) + BIT_VAL;
    end else begin
      rem_out  <= rem_in;
      root_out <= root_in >> 1;
    end
  end

endmodule

### rtl/core/ttsp_div_cell.sv
// ---------------------------------------------------------------------------
// ttsp_div_cell
// One registered restoring-division step that settles one quotient bit.
// ---------------------------------------------------------------------------
module ttsp_div_cell #(
  parameter int SHIFT = 0
) (
  input  logic                      clk,
  input  logic [ttsp_pkg::DW-1:0]   den,
  input  logic [ttsp_pkg::DW-1:0]   rem_in,
  input  logic [ttsp_pkg::QW-1:0]   q_in,
  output logic [ttsp_pkg::DW-1:0]   rem_out,
  output logic [ttsp_pkg::QW-1:0]   q_out
);

  logic [ttsp_pkg::DW-1:0] dsh;
  logic                    fits;

  // Compare against the divisor aligned to this quotient bit.
  assign dsh  = den << SHIFT;
  assign fits = rem_in >= dsh;

  always_ff @(posedge clk) begin
    if (fits) begin
      rem_out <= rem_in - dsh;
      q_out   <= q_in | (ttsp_pkg::QW'(1) << SHIFT);
    end else begin
      rem_out <= rem_in;
      q_out   <= q_in;
    end
  end

endmodule

### rtl/core/turn_then_straight_path_timing.sv
// ---------------------------------------------------------------------------
// turn_then_straight_path_timing
// Plans a turning arc plus a tangent run and reports their times.
// ---------------------------------------------------------------------------
// A transaction is taken at every rising edge with start high; busy is always
// low, so a new request may follow in every cycle. The result appears with
// done high for exactly one cycle, 2*CORDIC_STEPS+69 cycles after the request
// (101 cycles at the default), and must be captured then since the block has
// no way to hold it. That latency is set by the fully pipelined chain: a
// CORDIC cell per step for the rotation, a square-root cell per result bit,
// a second CORDIC row for the two bearings and a divider cell per quotient
// bit, plus a few multiply and setup stages. Configuration must be written
// only while no request is in flight.
module turn_then_straight_path_timing #(
  parameter int CORDIC_STEPS = 16,
  parameter int COORD_WIDTH  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] cur_x,
  input  logic signed [15:0] cur_y,
  input  logic signed [15:0] dest_x,
  input  logic signed [15:0] dest_y,
  input  logic signed [15:0] heading,
  output logic               done,
  output logic [26:0]        curve_time_us,
  output logic [26:0]        straight_time_us,
  output logic signed [15:0] new_heading,
  output logic               turn_right,
  output logic [15:0]        steer_duty,
  output logic               invalid
);

  localparam int RW = ttsp_pkg::RW;
  localparam int ZW = ttsp_pkg::ZW;
  localparam int DW = ttsp_pkg::DW;
  localparam int QW = ttsp_pkg::QW;
  localparam int NS = ttsp_pkg::SQRT_STEPS;

  // Configuration registers.
  logic [9:0]  right_turn_radius;
  logic [9:0]  left_turn_radius;
  logic [15:0] straight_speed;
  logic [15:0] curve_speed;
  logic [15:0] steer_center_duty;
  logic [15:0] steer_right_trim;
  logic [15:0] steer_left_trim;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel & penable & pwrite;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      right_turn_radius <= ttsp_pkg::RST_RIGHT_RADIUS;
      left_turn_radius  <= ttsp_pkg::RST_LEFT_RADIUS;
      straight_speed    <= ttsp_pkg::RST_STRAIGHT_SPD;
      curve_speed       <= ttsp_pkg::RST_CURVE_SPD;
      steer_center_duty <= ttsp_pkg::RST_CENTER_DUTY;
      steer_right_trim  <= ttsp_pkg::RST_RIGHT_TRIM;
      steer_left_trim   <= ttsp_pkg::RST_LEFT_TRIM;
    end else if (cfg_wr) begin
      case (ttsp_pkg::reg_idx_t'(paddr[4:2]))
        ttsp_pkg::REG_RIGHT_RADIUS: right_turn_radius <= pwdata[9:0];
        ttsp_pkg::REG_LEFT_RADIUS:  left_turn_radius  <= pwdata[9:0];
        ttsp_pkg::REG_STRAIGHT_SPD: straight_speed    <= pwdata[15:0];
        ttsp_pkg::REG_CURVE_SPD:    curve_speed       <= pwdata[15:0];
        ttsp_pkg::REG_CENTER_DUTY:  steer_center_duty <= pwdata[15:0];
        ttsp_pkg::REG_RIGHT_TRIM:   steer_right_trim  <= pwdata[15:0];
        ttsp_pkg::REG_LEFT_TRIM:    steer_left_trim   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (ttsp_pkg::reg_idx_t'(paddr[4:2]))
      ttsp_pkg::REG_RIGHT_RADIUS: prdata = {22'd0, right_turn_radius};
      ttsp_pkg::REG_LEFT_RADIUS:  prdata = {22'd0, left_turn_radius};
      ttsp_pkg::REG_STRAIGHT_SPD: prdata = {16'd0, straight_speed};
      ttsp_pkg::REG_CURVE_SPD:    prdata = {16'd0, curve_speed};
      ttsp_pkg::REG_CENTER_DUTY:  prdata = {16'd0, steer_center_duty};
      ttsp_pkg::REG_RIGHT_TRIM:   prdata = {16'd0, steer_right_trim};
      ttsp_pkg::REG_LEFT_TRIM:    prdata = {16'd0, steer_left_trim};
      default:                    prdata = 32'd0;
    endcase
  end

  // Coordinate as seen at COORD_WIDTH bits; always fits 17 signed bits.
  function automatic logic signed [16:0] coord_val(input logic [15:0] raw);
    logic [24:0] v;
    v = {9'd0, raw} & ((25'd1 << COORD_WIDTH) - 25'd1);
    if (v[COORD_WIDTH-1]) begin
      v = v - (25'd1 << COORD_WIDTH);
    end
    return $signed(v[16:0]);
  endfunction

  // Bearing angle clamped to the range zero to pi.
  function automatic logic [31:0] clamp_angle(input logic signed [ZW-1:0] z);
    logic [31:0] r;
    if (z < 0) begin
      r = 32'd0;
    end else if (z > ttsp_pkg::FULL_PI) begin
      r = 32'h8000_0000;
    end else begin
      r = z[31:0];
    end
    return r;
  endfunction

  // ------------------------------------------------------------ entry stage
  logic signed [17:0]   dx_w;
  logic signed [17:0]   dy_w;
  logic signed [RW-1:0] xa;
  logic signed [RW-1:0] ya;
  logic signed [ZW-1:0] za;
  logic signed [RW-1:0] xp;
  logic signed [RW-1:0] yp;
  logic signed [ZW-1:0] zp;
  ttsp_pkg::side_t      entry_side_next;

  logic signed [RW-1:0] rot_x [CORDIC_STEPS+1];
  logic signed [RW-1:0] rot_y [CORDIC_STEPS+1];
  logic signed [ZW-1:0] rot_z [CORDIC_STEPS+1];
  ttsp_pkg::side_t      rot_side [CORDIC_STEPS+1];

  // Offset to the destination in Q14 and the quadrant pre-rotation.
  always_comb begin
    dx_w = 18'(coord_val(dest_x)) - 18'(coord_val(cur_x));
    dy_w = 18'(coord_val(dest_y)) - 18'(coord_val(cur_y));
    xa   = RW'(dx_w) <<< 14;
    ya   = RW'(dy_w) <<< 14;
    za   = -(ZW'(heading) <<< 16);
    if (za > ttsp_pkg::HALF_PI) begin
      xp = -ya;
      yp = xa;
      zp = za - ttsp_pkg::HALF_PI;
    end else if (za < -ttsp_pkg::HALF_PI) begin
      xp = ya;
      yp = -xa;
      zp = za + ttsp_pkg::HALF_PI;
    end else begin
      xp = xa;
      yp = ya;
      zp = za;
    end
    entry_side_next         = '0;
    entry_side_next.valid   = start;
    entry_side_next.inv     = (dx_w == 0) && (dy_w == 0);
    entry_side_next.heading = heading;
  end

  always_ff @(posedge clk) begin
    rot_x[0] <= xp;
    rot_y[0] <= yp;
    rot_z[0] <= zp;
    if (rst) begin
      rot_side[0] <= '0;
    end else begin
      rot_side[0] <= entry_side_next;
    end
  end

  // Rotation by minus the heading, one cell per step.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    ttsp_cordic_cell #(.STEP(i), .VECTOR(1'b0)) u_cell (
      .clk   (clk),
      .x_in  (rot_x[i]),
      .y_in  (rot_y[i]),
      .z_in  (rot_z[i]),
      .x_out (rot_x[i+1]),
      .y_out (rot_y[i+1]),
      .z_out (rot_z[i+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        rot_side[i+1] <= '0;
      end else begin
        rot_side[i+1] <= rot_side[i];
      end
    end
  end

  // ---------------------------------------------------- gain partial products
  logic signed [42:0] g1_pxh;
  logic signed [42:0] g1_pyh;
  logic [40:0]        g1_pxl;
  logic [40:0]        g1_pyl;
  ttsp_pkg::side_t    g1_side;

  always_ff @(posedge clk) begin
    g1_pxh <= $signed(rot_x[CORDIC_STEPS][RW-1:17]) *
              $signed({1'b0, ttsp_pkg::INV_GAIN});
    g1_pyh <= $signed(rot_y[CORDIC_STEPS][RW-1:17]) *
              $signed({1'b0, ttsp_pkg::INV_GAIN});
    g1_pxl <= rot_x[CORDIC_STEPS][16:0] * ttsp_pkg::INV_GAIN;
    g1_pyl <= rot_y[CORDIC_STEPS][16:0] * ttsp_pkg::INV_GAIN;
    if (rst) begin
      g1_side <= '0;
    end else begin
      g1_side <= rot_side[CORDIC_STEPS];
    end
  end

  // -------------------------------------------------- gain sum and turn side
  logic signed [59:0]   fx;
  logic signed [59:0]   fy;
  logic signed [RW-1:0] gx;
  logic signed [RW-1:0] gy;
  logic signed [RW-1:0] gx_abs;
  logic signed [RW-1:0] gy_abs;
  logic                 g_right;
  ttsp_pkg::side_t      g2_side_next;
  ttsp_pkg::side_t      g2_side;

  always_comb begin
    fx      = (60'(g1_pxh) <<< 17) + $signed({19'd0, g1_pxl});
    fy      = (60'(g1_pyh) <<< 17) + $signed({19'd0, g1_pyl});
    gx      = $signed(fx[24+RW-1:24]);
    gy      = $signed(fy[24+RW-1:24]);
    gx_abs  = (gx < 0) ? -gx : gx;
    gy_abs  = (gy < 0) ? -gy : gy;
    g_right = (gy < 0) || ((gy == 0) && (gx < 0));
    g2_side_next       = g1_side;
    g2_side_next.right = g_right;
    g2_side_next.x_neg = gx < 0;
    g2_side_next.x_abs = gx_abs[33:0];
    g2_side_next.y_abs = gy_abs[33:0];
    g2_side_next.rad   = g_right ? right_turn_radius : left_turn_radius;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g2_side <= '0;
    end else begin
      g2_side <= g2_side_next;
    end
  end

  // ------------------------------------------------------------ squares
  logic [67:0]     sq_xx;
  logic [67:0]     sq_yy;
  logic [57:0]     sq_ry;
  ttsp_pkg::side_t sq_side_in;

  always_ff @(posedge clk) begin
    sq_xx <= g2_side.x_abs * g2_side.x_abs;
    sq_yy <= g2_side.y_abs * g2_side.y_abs;
    sq_ry <= {g2_side.rad, 14'd0} * g2_side.y_abs;
    if (rst) begin
      sq_side_in <= '0;
    end else begin
      sq_side_in <= g2_side;
    end
  end

  // -------------------------------------------- squared tangent length check
  logic signed [69:0] s2;
  ttsp_pkg::side_t    sq_side_next;
  logic [DW-1:0]      sq_rem  [NS+1];
  logic [DW-1:0]      sq_root [NS+1];
  ttsp_pkg::side_t    sq_side [NS+1];

  assign s2 = $signed({2'b0, sq_xx}) + $signed({2'b0, sq_yy}) -
              $signed({11'd0, sq_ry, 1'b0});

  // A negative squared length marks a destination inside the circle.
  always_comb begin
    sq_side_next     = sq_side_in;
    sq_side_next.inv = sq_side_in.inv | s2[69];
  end

  always_ff @(posedge clk) begin
    sq_rem[0]  <= s2[69] ? '0 : s2[DW-1:0];
    sq_root[0] <= '0;
    if (rst) begin
      sq_side[0] <= '0;
    end else begin
      sq_side[0] <= sq_side_next;
    end
  end

  // Square root, one cell per result bit.
  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    ttsp_sqrt_cell #(.STEP(i)) u_cell (
      .clk      (clk),
      .rem_in   (sq_rem[i]),
      .root_in  (sq_root[i]),
      .rem_out  (sq_rem[i+1]),
      .root_out (sq_root[i+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_side[i+1] <= '0;
      end else begin
        sq_side[i+1] <= sq_side[i];
      end
    end
  end

  // ------------------------------------------------------- bearing setup
  logic signed [RW-1:0] rf_s;
  logic signed [RW-1:0] xw;
  ttsp_pkg::side_t      vec_side_next;

  logic signed [RW-1:0] vt_x [CORDIC_STEPS+1];
  logic signed [RW-1:0] vt_y [CORDIC_STEPS+1];
  logic signed [ZW-1:0] vt_z [CORDIC_STEPS+1];
  logic signed [RW-1:0] vw_x [CORDIC_STEPS+1];
  logic signed [RW-1:0] vw_y [CORDIC_STEPS+1];
  logic signed [ZW-1:0] vw_z [CORDIC_STEPS+1];
  ttsp_pkg::side_t      vec_side [CORDIC_STEPS+1];

  assign rf_s = $signed({11'd0, sq_side[NS].rad, 14'd0});
  assign xw   = rf_s - $signed({1'b0, sq_side[NS].y_abs});

  // The root becomes the tangent length carried beside the bearings.
  always_comb begin
    vec_side_next      = sq_side[NS];
    vec_side_next.line = sq_root[NS][31:0];
  end

  always_ff @(posedge clk) begin
    vt_x[0] <= rf_s;
    vt_y[0] <= $signed({3'd0, sq_root[NS][31:0]});
    vt_z[0] <= '0;
    if (xw < 0) begin
      vw_x[0] <= $signed({1'b0, sq_side[NS].x_abs});
      vw_y[0] <= -xw;
      vw_z[0] <= ttsp_pkg::HALF_PI;
    end else begin
      vw_x[0] <= xw;
      vw_y[0] <= $signed({1'b0, sq_side[NS].x_abs});
      vw_z[0] <= '0;
    end
    if (rst) begin
      vec_side[0] <= '0;
    end else begin
      vec_side[0] <= vec_side_next;
    end
  end

  // Two vectoring rows side by side: tangent angle and center bearing.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    ttsp_cordic_cell #(.STEP(i), .VECTOR(1'b1)) u_th (
      .clk   (clk),
      .x_in  (vt_x[i]),
      .y_in  (vt_y[i]),
      .z_in  (vt_z[i]),
      .x_out (vt_x[i+1]),
      .y_out (vt_y[i+1]),
      .z_out (vt_z[i+1])
    );
    ttsp_cordic_cell #(.STEP(i), .VECTOR(1'b1)) u_w (
      .clk   (clk),
      .x_in  (vw_x[i]),
      .y_in  (vw_y[i]),
      .z_in  (vw_z[i]),
      .x_out (vw_x[i+1]),
      .y_out (vw_y[i+1]),
      .z_out (vw_z[i+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        vec_side[i+1] <= '0;
      end else begin
        vec_side[i+1] <= vec_side[i];
      end
    end
  end

  // ----------------------------------------------- arc angle and heading
  ttsp_pkg::side_t    vs;
  logic [31:0]        th1;
  logic [31:0]        wang;
  logic [33:0]        phi;
  logic signed [34:0] turn_s;
  logic [32:0]        turn;
  logic [33:0]        tb_sum;
  logic [16:0]        duty_sum;
  logic [15:0]        f_new_h;
  logic [15:0]        f_duty;
  ttsp_pkg::side_t    f0_side_next;
  logic [42:0]        f0_tr;
  logic [45:0]        f0_ln;
  ttsp_pkg::side_t    f0_side;

  always_comb begin
    vs       = vec_side[CORDIC_STEPS];
    th1      = clamp_angle(vt_z[CORDIC_STEPS]);
    wang     = clamp_angle(vw_z[CORDIC_STEPS]);
    phi      = vs.x_neg ? (34'h1_0000_0000 - {2'b0, wang}) : {2'b0, wang};
    turn_s   = $signed({1'b0, phi}) - $signed({3'b0, th1});
    turn     = turn_s[34] ? '0 : turn_s[32:0];
    tb_sum   = {1'b0, turn} + 34'd32768;
    duty_sum = {1'b0, steer_center_duty} + {1'b0, steer_right_trim};
    if (vs.right) begin
      f_new_h = vs.heading - tb_sum[31:16];
      f_duty  = duty_sum[16] ? 16'hFFFF : duty_sum[15:0];
    end else begin
      f_new_h = vs.heading + tb_sum[31:16];
      f_duty  = (steer_left_trim > steer_center_duty) ? 16'd0 :
                (steer_center_duty - steer_left_trim);
    end
    f0_side_next       = vs;
    f0_side_next.new_h = f_new_h;
    f0_side_next.duty  = f_duty;
  end

  always_ff @(posedge clk) begin
    f0_tr <= turn * vs.rad;
    f0_ln <= vs.line * ttsp_pkg::LINE_K;
    if (rst) begin
      f0_side <= '0;
    end else begin
      f0_side <= f0_side_next;
    end
  end

  // ------------------------------------------------------- arc numerator
  logic [61:0]     f1_num;
  logic [45:0]     f1_ln;
  ttsp_pkg::side_t f1_side;

  always_ff @(posedge clk) begin
    f1_num <= f0_tr * ttsp_pkg::ARC_K;
    f1_ln  <= f0_ln;
    if (rst) begin
      f1_side <= '0;
    end else begin
      f1_side <= f0_side;
    end
  end

  // -------------------------------------------- rounding and saturation
  logic [DW-1:0]   den1;
  logic [DW-1:0]   den2;
  logic [DW-1:0]   n1;
  logic [DW-1:0]   n2;
  ttsp_pkg::side_t dv_side_next;
  logic [DW-1:0]   dv1_rem [QW+1];
  logic [QW-1:0]   dv1_q   [QW+1];
  logic [DW-1:0]   dv2_rem [QW+1];
  logic [QW-1:0]   dv2_q   [QW+1];
  ttsp_pkg::side_t dv_side [QW+1];

  assign den1 = {28'd0, curve_speed, 20'd0};
  assign den2 = {48'd0, straight_speed};
  assign n1   = {2'b0, f1_num} + {29'd0, curve_speed, 19'd0};
  assign n2   = {18'd0, f1_ln} + {49'd0, straight_speed[15:1]};

  // Saturation and nonzero flags for both times.
  always_comb begin
    dv_side_next      = f1_side;
    dv_side_next.sat1 = n1 >= {1'b0, curve_speed, 47'd0};
    dv_side_next.sat2 = n2 >= {21'd0, straight_speed, 27'd0};
    dv_side_next.nz1  = f1_num != '0;
    dv_side_next.nz2  = f1_ln != '0;
  end

  always_ff @(posedge clk) begin
    dv1_rem[0] <= n1;
    dv2_rem[0] <= n2;
    dv1_q[0]   <= '0;
    dv2_q[0]   <= '0;
    if (rst) begin
      dv_side[0] <= '0;
    end else begin
      dv_side[0] <= dv_side_next;
    end
  end

  // Two dividers, one cell per quotient bit from the top down.
  for (genvar i = 0; i < QW; i++) begin : g_div
    ttsp_div_cell #(.SHIFT(QW - 1 - i)) u_arc (
      .clk     (clk),
      .den     (den1),
      .rem_in  (dv1_rem[i]),
      .q_in    (dv1_q[i]),
      .rem_out (dv1_rem[i+1]),
      .q_out   (dv1_q[i+1])
    );
    ttsp_div_cell #(.SHIFT(QW - 1 - i)) u_line (
      .clk     (clk),
      .den     (den2),
      .rem_in  (dv2_rem[i]),
      .q_in    (dv2_q[i]),
      .rem_out (dv2_rem[i+1]),
      .q_out   (dv2_q[i+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_side[i+1] <= '0;
      end else begin
        dv_side[i+1] <= dv_side[i];
      end
    end
  end

  // ------------------------------------------------------ result register
  ttsp_pkg::side_t os;
  logic [QW-1:0]   ct;
  logic [QW-1:0]   st;

  always_comb begin
    os = dv_side[QW];
    if (curve_speed == 16'd0) begin
      ct = os.nz1 ? ttsp_pkg::TIME_MAX : '0;
    end else begin
      ct = os.sat1 ? ttsp_pkg::TIME_MAX : dv1_q[QW];
    end
    if (straight_speed == 16'd0) begin
      st = os.nz2 ? ttsp_pkg::TIME_MAX : '0;
    end else begin
      st = os.sat2 ? ttsp_pkg::TIME_MAX : dv2_q[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= os.valid;
    end
    invalid          <= os.inv;
    curve_time_us    <= os.inv ? '0 : ct;
    straight_time_us <= os.inv ? '0 : st;
    new_heading      <= os.inv ? os.heading : os.new_h;
    turn_right       <= os.inv ? 1'b0 : os.right;
    steer_duty       <= os.inv ? steer_center_duty : os.duty;
  end

endmodule

### rtl/core/ttsp_checker.sv
// ---------------------------------------------------------------------------
// ttsp_checker
// Port-level checks on the path timing block, bound to its top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ttsp_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic signed [15:0] heading,
  input logic               done,
  input logic               invalid,
  input logic [26:0]        curve_time_us,
  input logic [26:0]        straight_time_us,
  input logic signed [15:0] new_heading,
  input logic               turn_right
);

  localparam int LAT = 2 * CORDIC_STEPS + 69;

  // The pipeline never refuses a request.
  `ASSERT_ALWAYS(a_never_busy, clk, rst, !busy)

  // Every result comes from a request that has run through the whole pipeline.
  `ASSERT_IMPLY(a_latency, clk, rst, done, $past(start, LAT))

  // A degenerate request reports zero times and a left turn.
  `ASSERT_IMPLY(a_inv_zero, clk, rst, done && invalid, curve_time_us == 0 && straight_time_us == 0 && !turn_right)

  // A degenerate request keeps its heading.
  `ASSERT_IMPLY(a_inv_heading, clk, rst, done && invalid, new_heading == $past(heading, LAT))

endmodule

bind turn_then_straight_path_timing ttsp_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_ttsp_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .heading          (heading),
  .done             (done),
  .invalid          (invalid),
  .curve_time_us    (curve_time_us),
  .straight_time_us (straight_time_us),
  .new_heading      (new_heading),
  .turn_right       (turn_right)
);

### verif/turn_then_straight_path_timing_tb.sv
// ----------------------------------------------------------------------------
// Testbench for the turn-then-straight path timing block
// Drives waypoint requests through the command port and checks every result.
// A behavioral predictor computes each expected result from its own copy of
// the register settings. Registers are set over APB between phases, once the
// pipeline has drained.
// ----------------------------------------------------------------------------
module turn_then_straight_path_timing_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 16;
  localparam int LATENCY = 2 * STEPS + 69;
  localparam longint CYCLE_LIMIT = 400000;
  localparam longint HALF_ANG = 64'sd1073741824;
  localparam longint FULL_ANG = 64'sd2147483648;
  localparam longint TWO_ANG = 64'sd4294967296;
  localparam longint unsigned SAT_TIME = 64'd134217727;

  typedef struct packed {
    logic [26:0] curve_t;
    logic [26:0] straight_t;
    logic [15:0] head;
    logic        right;
    logic [15:0] duty;
    logic        inv;
  } plan_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic start;
  logic busy;
  logic signed [15:0] cur_x, cur_y, dest_x, dest_y, heading;
  logic done;
  logic [26:0] curve_time_us, straight_time_us;
  logic signed [15:0] new_heading;
  logic turn_right;
  logic [15:0] steer_duty;
  logic invalid;

  // Predictor copy of the register file.
  logic [9:0]  m_right_rad, m_left_rad;
  logic [15:0] m_line_spd, m_arc_spd, m_center, m_rtrim, m_ltrim;

  plan_t pending_plans[$];
  int    fail_count;
  longint cycles;
  bit    idle_on;

  turn_then_straight_path_timing uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .cur_x(cur_x), .cur_y(cur_y),
    .dest_x(dest_x), .dest_y(dest_y), .heading(heading), .done(done),
    .curve_time_us(curve_time_us), .straight_time_us(straight_time_us),
    .new_heading(new_heading), .turn_right(turn_right),
    .steer_duty(steer_duty), .invalid(invalid)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Rotate a vector by angle z (2^31 = pi) and remove the CORDIC gain.
  task automatic cordic_rotate(inout longint x, inout longint y, input longint z);
    longint t, sx, sy;
    if (z > HALF_ANG) begin
      t = x; x = -y; y = t; z = z - HALF_ANG;
    end else if (z < -HALF_ANG) begin
      t = x; x = y; y = -t; z = z + HALF_ANG;
    end
    for (int i = 0; i < STEPS; i++) begin
      sx = x >>> i;
      sy = y >>> i;
      if (z >= 0) begin
        x = x - sy; y = y + sx; z = z - longint'(ttsp_pkg::ANGLE_STEP[i]);
      end else begin
        x = x + sy; y = y - sx; z = z + longint'(ttsp_pkg::ANGLE_STEP[i]);
      end
    end
    x = (x * longint'(ttsp_pkg::INV_GAIN)) >>> 24;
    y = (y * longint'(ttsp_pkg::INV_GAIN)) >>> 24;
  endtask

  // Angle of (x, y) for y >= 0, clamped to [0, pi].
  function automatic longint vector_angle(longint y, longint x);
    longint z, t, sx, sy;
    z = 0;
    if (x < 0) begin
      t = x; x = y; y = -t; z = HALF_ANG;
    end
    for (int i = 0; i < STEPS; i++) begin
      sx = x >>> i;
      sy = y >>> i;
      if (y > 0) begin
        x = x + sy; y = y - sx; z = z + longint'(ttsp_pkg::ANGLE_STEP[i]);
      end else begin
        x = x - sy; y = y + sx; z = z - longint'(ttsp_pkg::ANGLE_STEP[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > FULL_ANG) z = FULL_ANG;
    return z;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Rounded quotient in microseconds, saturating; zero speed saturates a nonzero numerator.
  function automatic logic [26:0] travel_us(longint unsigned num, longint unsigned den);
    longint unsigned q;
    if (den == 0) return (num != 0) ? SAT_TIME[26:0] : 27'd0;
    q = (num + den / 2) / den;
    return (q > SAT_TIME) ? SAT_TIME[26:0] : q[26:0];
  endfunction

  // Expected arc/straight plan for one waypoint request.
  task automatic plan_path(input logic [15:0] cx, input logic [15:0] cy,
                           input logic [15:0] tx, input logic [15:0] ty,
                           input logic [15:0] hd, output plan_t p);
    longint dx, dy, h, x, y, rf, s2, line, th1, w, phi, turn;
    longint unsigned rad, tb, duty;
    bit right;
    dx = longint'($signed(tx)) - longint'($signed(cx));
    dy = longint'($signed(ty)) - longint'($signed(cy));
    h = longint'($signed(hd));
    p = '0;
    p.head = hd;
    p.duty = m_center;
    p.inv = 1'b1;
    if (dx == 0 && dy == 0) return;
    x = dx * 16384;
    y = dy * 16384;
    cordic_rotate(x, y, -h * 65536);
    // A destination exactly behind counts as a right turn.
    right = (y < 0) || (y == 0 && x < 0);
    if (y < 0) y = -y;
    rad = right ? longint'(m_right_rad) : longint'(m_left_rad);
    rf = longint'(rad) * 16384;
    s2 = x * x + y * y - 2 * rf * y;
    // Destination inside the turning circle.
    if (s2 < 0) return;
    line = longint'(int_sqrt(s2));
    th1 = vector_angle(line, rf);
    w = vector_angle((x < 0) ? -x : x, rf - y);
    phi = (x >= 0) ? w : TWO_ANG - w;
    turn = phi - th1;
    if (turn < 0) turn = 0;
    tb = (longint'(turn) + 32768) >> 16;
    if (right) begin
      p.head = hd - tb[15:0];
      duty = longint'(m_center) + longint'(m_rtrim);
      if (duty > 65535) duty = 65535;
    end else begin
      p.head = hd + tb[15:0];
      duty = (m_ltrim > m_center) ? 0 : longint'(m_center - m_ltrim);
    end
    p.curve_t = travel_us(longint'(turn) * rad * longint'(ttsp_pkg::ARC_K),
                          longint'(m_arc_spd) << 20);
    p.straight_t = travel_us(longint'(line) * longint'(ttsp_pkg::LINE_K),
                             longint'(m_line_spd));
    p.right = right;
    p.duty = duty[15:0];
    p.inv = 1'b0;
  endtask

  // Result checker: each done pulse is matched against the oldest plan.
  always @(posedge clk) begin
    plan_t exp_p, act_p;
    if (!rst && done) begin
      act_p = '{curve_time_us, straight_time_us, new_heading, turn_right,
                steer_duty, invalid};
      if (pending_plans.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("Unexpected result %p", act_p);
      end else begin
        exp_p = pending_plans.pop_front();
        if (act_p !== exp_p) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Mismatch: expected %p, actual %p", exp_p, act_p);
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Write one register through an APB setup phase and an access phase.
  task automatic write_reg(input ttsp_pkg::reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      ttsp_pkg::REG_RIGHT_RADIUS: m_right_rad = val[9:0];
      ttsp_pkg::REG_LEFT_RADIUS:  m_left_rad = val[9:0];
      ttsp_pkg::REG_STRAIGHT_SPD: m_line_spd = val[15:0];
      ttsp_pkg::REG_CURVE_SPD:    m_arc_spd = val[15:0];
      ttsp_pkg::REG_CENTER_DUTY:  m_center = val[15:0];
      ttsp_pkg::REG_RIGHT_TRIM:   m_rtrim = val[15:0];
      default:                    m_ltrim = val[15:0];
    endcase
  endtask

  task automatic set_all_regs(input logic [9:0] rr, input logic [9:0] lr,
                              input logic [15:0] ss, input logic [15:0] cs,
                              input logic [15:0] cd, input logic [15:0] rt,
                              input logic [15:0] lt);
    write_reg(ttsp_pkg::REG_RIGHT_RADIUS, 32'(rr));
    write_reg(ttsp_pkg::REG_LEFT_RADIUS, 32'(lr));
    write_reg(ttsp_pkg::REG_STRAIGHT_SPD, 32'(ss));
    write_reg(ttsp_pkg::REG_CURVE_SPD, 32'(cs));
    write_reg(ttsp_pkg::REG_CENTER_DUTY, 32'(cd));
    write_reg(ttsp_pkg::REG_RIGHT_TRIM, 32'(rt));
    write_reg(ttsp_pkg::REG_LEFT_TRIM, 32'(lt));
  endtask

  // Stop issuing and let every transaction in flight come out.
  task automatic drain_pipe();
    @(negedge clk);
    start <= 1'b0;
    while (pending_plans.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // Issue one waypoint request, with random idle cycles in front of it when idle_on is set.
  task automatic send_request(input logic [15:0] cx, input logic [15:0] cy,
                              input logic [15:0] tx, input logic [15:0] ty,
                              input logic [15:0] hd);
    plan_t p;
    while (idle_on && $urandom_range(99) < 27) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    cur_x <= cx; cur_y <= cy; dest_x <= tx; dest_y <= ty; heading <= hd;
    plan_path(cx, cy, tx, ty, hd, p);
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_plans.push_back(p);
  endtask

  // One random request, weighted toward geometry near the turning circle.
  task automatic random_request(input int span);
    logic [15:0] cx, cy, tx, ty, hd, n;
    int mode;
    cx = 16'($urandom); cy = 16'($urandom); hd = 16'($urandom);
    mode = $urandom_range(99);
    if (mode < 40) begin
      tx = cx + 16'($signed($urandom_range(2 * span)) - span);
      ty = cy + 16'($signed($urandom_range(2 * span)) - span);
    end else if (mode < 48) begin
      tx = cx; ty = cy;
    end else if (mode < 63) begin
      // On the heading line, ahead or behind, along an axis.
      n = 16'($urandom_range(1, 3 * span));
      if ($urandom_range(1)) n = -n;
      case ($urandom_range(3))
        0: begin hd = 16'h0000; tx = cx + n; ty = cy; end
        1: begin hd = 16'h4000; tx = cx; ty = cy + n; end
        2: begin hd = 16'hC000; tx = cx; ty = cy + n; end
        default: begin hd = 16'h8000; tx = cx + n; ty = cy; end
      endcase
    end else if (mode < 83) begin
      tx = 16'($urandom); ty = 16'($urandom);
    end else begin
      tx = cx + 16'($signed($urandom_range(4000)) - 2000);
      ty = cy + 16'($signed($urandom_range(4000)) - 2000);
    end
    send_request(cx, cy, tx, ty, hd);
  endtask

  // Directed cases at the reset settings.
  task automatic test_directed_geometry();
    idle_on = 1'b0;
    send_request(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
    send_request(16'd0, 16'd0, 16'd100, 16'd0, 16'd0);
    send_request(16'd0, 16'd0, -16'sd100, 16'd0, 16'd0);
    send_request(16'd0, 16'd0, 16'd0, 16'd60, 16'd0);
    send_request(16'd0, 16'd0, 16'd0, -16'sd68, 16'd0);
    send_request(16'd0, 16'd0, 16'd5, 16'd10, 16'd0);
    send_request(16'd0, 16'd0, 16'd5, -16'sd10, 16'd0);
    send_request(16'd0, 16'd0, 16'd200, 16'd500, 16'h4000);
    send_request(16'd0, 16'd0, -16'sd300, -16'sd40, 16'h8000);
    send_request(16'd0, 16'd0, -16'sd300, 16'd40, 16'h7FFF);
    send_request(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'd0);
    send_request(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
    send_request(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'hC000);
    send_request(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    send_request(16'd0, 16'd0, 16'd0, 16'd1000, 16'h4000);
    send_request(16'd0, 16'd0, 16'd0, -16'sd1000, 16'h4000);
    send_request(16'd10, 16'd10, 16'd10, 16'd11, 16'h0001);
    drain_pipe();
  endtask

  // Register extremes, including zero radius and zero speed.
  task automatic test_register_extremes();
    set_all_regs(10'd1023, 10'd1023, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
                 16'd65535);
    repeat (40) random_request(3000);
    drain_pipe();
    set_all_regs(10'd1, 10'd1, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0);
    repeat (40) random_request(20);
    drain_pipe();
    set_all_regs(10'd0, 10'd0, 16'd0, 16'd0, 16'd100, 16'd200, 16'd300);
    repeat (40) random_request(50);
    drain_pipe();
    set_all_regs(10'd0, 10'd1023, 16'd0, 16'd65535, 16'd0, 16'd65535, 16'd1);
    repeat (40) random_request(2000);
    drain_pipe();
  endtask

  // Random requests over several random register settings.
  task automatic test_random_sweeps();
    logic [9:0] rr, lr;
    for (int ph = 0; ph < 10; ph++) begin
      rr = (ph % 3 == 0) ? 10'($urandom_range(1, 1023)) : 10'($urandom_range(1, 60));
      lr = (ph % 3 == 0) ? 10'($urandom_range(1, 1023)) : 10'($urandom_range(1, 60));
      set_all_regs(rr, lr, 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                   16'($urandom), 16'($urandom), 16'($urandom));
      // Phase three runs back to back with no idle cycles.
      idle_on = (ph != 3);
      repeat (117) random_request((rr > lr ? rr : lr) * 3 + 4);
      drain_pipe();
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    start = 1'b0;
    cur_x = '0; cur_y = '0; dest_x = '0; dest_y = '0; heading = '0;
    fail_count = 0;
    cycles = 0;
    idle_on = 1'b1;
    m_right_rad = ttsp_pkg::RST_RIGHT_RADIUS; m_left_rad = ttsp_pkg::RST_LEFT_RADIUS;
    m_line_spd = ttsp_pkg::RST_STRAIGHT_SPD; m_arc_spd = ttsp_pkg::RST_CURVE_SPD;
    m_center = ttsp_pkg::RST_CENTER_DUTY; m_rtrim = ttsp_pkg::RST_RIGHT_TRIM;
    m_ltrim = ttsp_pkg::RST_LEFT_TRIM;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_geometry();
    test_register_extremes();
    test_random_sweeps();
    drain_pipe();
    if (fail_count == 0 && pending_plans.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
